>>> rtl/core/cats_pkg.sv
// ----------------------------------------------------------------------------
// cats_pkg: shared types and helpers of the token splitter
// Character codes, lexer state and result records, and the two result
// builders used by the lexer step.
// ----------------------------------------------------------------------------
package cats_pkg;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CRET    = 8'h0D;

   localparam int MAX_RES = 3;
   localparam int QDEPTH  = 4;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_LINE   = 3'd1,
      MODE_BLOCK  = 3'd2,
      MODE_STR    = 3'd3,
      MODE_CHR    = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     slash_pending;
      logic     star_seen;
      logic     prev_backslash;
      logic     token_open;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '{
      mode: MODE_NORMAL, slash_pending: 1'b0, star_seen: 1'b0,
      prev_backslash: 1'b0, token_open: 1'b0
   };

   typedef struct packed {
      logic       has_char;
      logic [7:0] out_char;
      logic       token_end;
      logic       last_of_run;
   } res_entry_type;

   typedef struct packed {
      logic [1:0]                  n;
      logic                        tok;
      res_entry_type [MAX_RES-1:0] ent;
   } work_type;

   function automatic work_type put_char(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      if (r.n < 2'(MAX_RES)) begin
         r.ent[r.n] = '{has_char: 1'b1, out_char: c, token_end: 1'b0,
                        last_of_run: 1'b0};
         r.n = r.n + 2'd1;
      end
      r.tok = 1'b1;
      return r;
   endfunction

   function automatic work_type end_token(work_type w);
      work_type   r;
      logic [1:0] top;
      r   = w;
      top = r.n - 2'd1;
      if (r.tok) begin
         r.tok = 1'b0;
         if (r.n != 2'd0 && r.ent[top].has_char && !r.ent[top].token_end) begin
            r.ent[top].token_end = 1'b1;
         end else if (r.n < 2'(MAX_RES)) begin
            r.ent[r.n] = '{has_char: 1'b0, out_char: 8'h00, token_end: 1'b1,
                           last_of_run: 1'b0};
            r.n = r.n + 2'd1;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/cats_lexer.sv
// ----------------------------------------------------------------------------
// cats_lexer: one lexer step
// From the current lexer state and one source byte, forms the next state
// and the up to three result words that the byte causes.
// ----------------------------------------------------------------------------
module cats_lexer
   import cats_pkg::*;
(
   input  lex_state_type state,
   input  logic [7:0]    ch,
   input  logic          end_of_input,
   output lex_state_type state_next,
   output work_type      results
);

   lex_state_type nx;
   work_type      w;
   logic [7:0]    quote;
   logic          escaped;
   logic          go_on;

   always_comb begin
      nx      = state;
      w       = '0;
      w.tok   = state.token_open;
      quote   = (state.mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
      escaped = state.prev_backslash;
      go_on   = 1'b0;

      case (state.mode)
         MODE_LINE: begin
            if (ch == CH_NEWLINE) nx.mode = MODE_NORMAL;
         end
         MODE_BLOCK: begin
            if (state.star_seen && ch == CH_SLASH) begin
               nx.mode      = MODE_NORMAL;
               nx.star_seen = 1'b0;
            end else begin
               nx.star_seen = (ch == CH_STAR);
            end
         end
         MODE_STR, MODE_CHR: begin
            w = put_char(w, ch);
            nx.prev_backslash = (ch == CH_BSLASH) && !escaped;
            if (ch == quote && !escaped) begin
               w = end_token(w);
               nx.mode = MODE_NORMAL;
               nx.prev_backslash = 1'b0;
            end
         end
         default: begin
            nx.mode = MODE_NORMAL;
            go_on   = 1'b1;
            if (state.slash_pending) begin
               nx.slash_pending = 1'b0;
               if (ch == CH_SLASH || ch == CH_STAR) begin
                  w = end_token(w);
                  nx.mode      = (ch == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                  nx.star_seen = 1'b0;
                  go_on        = 1'b0;
               end else begin
                  w = put_char(w, CH_SLASH);
               end
            end
            if (go_on) begin
               if (ch == CH_SLASH) begin
                  nx.slash_pending = 1'b1;
               end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
                  w = put_char(w, ch);
                  nx.mode = (ch == CH_DQUOTE) ? MODE_STR : MODE_CHR;
                  nx.prev_backslash = 1'b0;
               end else if (ch inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB,
                                       CH_FFEED, CH_CRET}) begin
                  w = end_token(w);
               end else begin
                  w = put_char(w, ch);
               end
            end
         end
      endcase

      if (end_of_input) begin
         if (nx.slash_pending) w = put_char(w, CH_SLASH);
         w = end_token(w);
      end

      nx.token_open = w.tok;
      if (end_of_input) nx = LEX_RESET;

      if (w.n != 2'd0) w.ent[w.n - 2'd1].last_of_run = 1'b1;

      state_next = nx;
      results    = w;
   end

endmodule

>>> rtl/core/comment_aware_token_splitter.sv
// ----------------------------------------------------------------------------
// comment_aware_token_splitter: C-style comment and literal aware lexer
// Passes on token characters of a byte stream with token end markers,
// dropping comments and whitespace outside string and character literals.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while req_stall is low. A byte enters
// an input register, the lexer step works on it in the next cycle and
// writes its zero to three result words into a four-entry result queue,
// from which one word leaves per cycle while rsp_stall is low; the first
// result of a byte reaches the result port through the input register and
// the queue. A byte is held in the input register while the queue lacks
// room for all of its results, so bytes that give more than one word (a
// held slash that turns out not to open a comment, passed on ahead of the
// byte that follows it) can hold up later bytes while their words drain.
// The lexer returns to its reset state after a byte marked end of input.
module comment_aware_token_splitter
   import cats_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_char,
   output logic [7:0] rsp_out_char,
   output logic       rsp_token_end,
   output logic       rsp_last_of_run
);

   logic          in_vld_ff, in_vld_in;
   logic [7:0]    in_ch_ff;
   logic          in_eoi_ff;
   lex_state_type state_ff, state_in;
   res_entry_type q_ff [QDEPTH];
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [2:0]    count_ff, count_in;

   work_type      step;
   logic          pop;
   logic          consume;
   logic [2:0]    room;

   cats_lexer u_lexer (
      .state        (state_ff),
      .ch           (in_ch_ff),
      .end_of_input (in_eoi_ff),
      .state_next   (state_in),
      .results      (step)
   );

   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = 3'(QDEPTH) - count_ff + {2'b00, pop};
   assign consume   = in_vld_ff && (room >= {1'b0, step.n});
   assign req_stall = in_vld_ff && !consume;

   assign in_vld_in = req_valid || (in_vld_ff && !consume);
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign wr_ptr_in = consume ? wr_ptr_ff + step.n : wr_ptr_ff;
   assign count_in  = count_ff + (consume ? {1'b0, step.n} : 3'd0) - {2'b00, pop};

   assign rsp_has_char    = q_ff[rd_ptr_ff].has_char;
   assign rsp_out_char    = q_ff[rd_ptr_ff].out_char;
   assign rsp_token_end   = q_ff[rd_ptr_ff].token_end;
   assign rsp_last_of_run = q_ff[rd_ptr_ff].last_of_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= LEX_RESET;
         rd_ptr_ff <= 2'd0;
         wr_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (consume) state_ff <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff  <= req_ch;
         in_eoi_ff <= req_end_of_input;
      end
      for (int i = 0; i < MAX_RES; i++) begin
         if (consume && 2'(i) < step.n) q_ff[wr_ptr_ff + 2'(i)] <= step.ent[i];
      end
   end

   // The result queue never holds more words than it has entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 3'(QDEPTH))
      else $error("result queue overfilled");

   // Every byte that yields results closes its run with a last marker.
   assert property (@(posedge clock) disable iff (reset)
      consume && step.n != 2'd0 |-> step.ent[step.n - 2'd1].last_of_run)
      else $error("result run lacks last marker");

   // A byte that yields results leaves the queue non-empty.
   assert property (@(posedge clock) disable iff (reset)
      consume && step.n != 2'd0 |=> count_ff != 3'd0)
      else $error("results of a byte were lost");

   // End of input returns the lexer to its reset state.
   assert property (@(posedge clock) disable iff (reset)
      consume && in_eoi_ff |=> state_ff == LEX_RESET)
      else $error("lexer state not cleared at end of input");

endmodule
